>>> hdl/knn_pkg.sv
// shared types, constants and codes of the k nearest neighbor selector
package knn_pkg;

   // parameter defaults
   localparam int K_MAX_DEFAULT       = 16;
   localparam int INDEX_WIDTH_DEFAULT = 20;
   localparam int COORD_WIDTH_DEFAULT = 16;

   // fixed field widths of the ports
   localparam int FIELD_COORD_W = 16;
   localparam int FIELD_COUNT_W = 5;
   localparam int OUT_INDEX_W   = 20;
   localparam int OUT_DIST_W    = 34;
   localparam int OUT_RANK_W    = 4;
   localparam int CSR_INDEX_W   = 2;

   // register map of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NEIGHBOR_COUNT = 2'd0,
      CSR_QUERY_X        = 2'd1,
      CSR_QUERY_Y        = 2'd2,
      CSR_QUERY_Z        = 2'd3
   } csr_index_type;

   // one cloud point
   typedef struct packed {
      logic signed [FIELD_COORD_W-1:0] point_x;
      logic signed [FIELD_COORD_W-1:0] point_y;
      logic signed [FIELD_COORD_W-1:0] point_z;
      logic                            end_of_cloud;
   } req_payload_type;

   // one neighbor result
   typedef struct packed {
      logic [OUT_INDEX_W-1:0] neighbor_index;
      logic [OUT_DIST_W-1:0]  sqr_distance;
      logic [OUT_RANK_W-1:0]  rank;
      logic                   empty_result;
      logic                   last_of_run;
   } rsp_payload_type;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_INSERT,
      ST_EMIT
   } knn_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic square;
      logic sum;
      logic insert;
      logic emit;
   } knn_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic end_of_cloud;
      logic out_free;
      logic emit_done;
   } knn_status_type;

endpackage

>>> hdl/k_nearest_neighbor_select.sv
// top level of the streaming k nearest neighbor selector
// Points arrive on the req_ channel as signed x, y, z and are numbered from 0 in
// arrival order; the block keeps the k nearest (k = neighbor_count, capped at
// K_MAX) to the query point sorted by squared distance, a new point going ahead
// of stored points at equal distance. Each point passes through accept with
// the coordinate differences, square, sum of squares, and one compare-and-shift
// step of the sorted register row; the next point is taken only after that step.
// On a point marked end_of_cloud the list follows on the rsp_ channel, nearest
// first, one result per cycle out of the result register while rsp_stall is low,
// with last_of_run on the final one; an empty cloud or k of zero gives a single
// result flagged empty_result. The list and numbering then restart, and the next
// point may be accepted while the final result still waits. Points beyond the
// INDEX_WIDTH numbering range are ignored. Write the csr_ registers only while
// the block is idle.
module k_nearest_neighbor_select #(
   parameter int K_MAX       = knn_pkg::K_MAX_DEFAULT,
   parameter int INDEX_WIDTH = knn_pkg::INDEX_WIDTH_DEFAULT,
   parameter int COORD_WIDTH = knn_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  knn_pkg::csr_index_type            csr_index,
   input  logic [knn_pkg::FIELD_COORD_W-1:0] csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  knn_pkg::req_payload_type          req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output knn_pkg::rsp_payload_type          rsp_payload
);
   import knn_pkg::*;

   knn_cmd_type    cmd;
   knn_status_type status;

   // sequencing
   knn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and storage
   knn_datapath #(
      .K_MAX       (K_MAX),
      .INDEX_WIDTH (INDEX_WIDTH),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_payload      (req_payload),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

endmodule

>>> hdl/knn_ctrl.sv
// sequencing state machine of the k nearest neighbor selector
module knn_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  knn_pkg::knn_status_type status,
   output knn_pkg::knn_cmd_type    cmd
);
   import knn_pkg::*;

   knn_state_type state_ff;
   knn_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_INSERT;
         end
         ST_INSERT: begin
            state_in = status.end_of_cloud ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free && status.emit_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // at most one datapath step per cycle
   assert property (@(posedge clock) disable iff (reset) $onehot0(cmd))
      else $error("knn_ctrl: more than one command at once");

   // an insertion ends either in idle or in emission
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INSERT) |=> (state_ff == ST_IDLE || state_ff == ST_EMIT))
      else $error("knn_ctrl: bad state after insertion");

endmodule

>>> hdl/knn_datapath.sv
// distance arithmetic, sorted neighbor row and result register
module knn_datapath #(
   parameter int K_MAX       = knn_pkg::K_MAX_DEFAULT,
   parameter int INDEX_WIDTH = knn_pkg::INDEX_WIDTH_DEFAULT,
   parameter int COORD_WIDTH = knn_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  knn_pkg::csr_index_type                  csr_index,
   input  logic [knn_pkg::FIELD_COORD_W-1:0]       csr_write_data,
   input  knn_pkg::req_payload_type                req_payload,
   input  knn_pkg::knn_cmd_type                    cmd,
   output knn_pkg::knn_status_type                 status,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output knn_pkg::rsp_payload_type                rsp_payload
);
   import knn_pkg::*;

   localparam int CNT_W      = $clog2(K_MAX + 1);
   localparam int KCMP_W     = (CNT_W > FIELD_COUNT_W) ? CNT_W : FIELD_COUNT_W;
   localparam int ARR_W      = INDEX_WIDTH + 1;
   localparam int CX_W       = (COORD_WIDTH > FIELD_COORD_W) ? COORD_WIDTH : FIELD_COORD_W;
   localparam int DIFF_W     = COORD_WIDTH + 1;
   localparam int SQ_W       = 2 * DIFF_W;
   localparam int DIST_W     = SQ_W + 2;
   localparam int IDX_EXT_W  = INDEX_WIDTH + OUT_INDEX_W;
   localparam int DIST_EXT_W = DIST_W + OUT_DIST_W;

   // configuration registers
   logic [FIELD_COUNT_W-1:0] neighbor_count_ff;
   logic [FIELD_COORD_W-1:0] query_x_ff;
   logic [FIELD_COORD_W-1:0] query_y_ff;
   logic [FIELD_COORD_W-1:0] query_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         neighbor_count_ff <= FIELD_COUNT_W'(1);
         query_x_ff        <= '0;
         query_y_ff        <= '0;
         query_z_ff        <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_NEIGHBOR_COUNT: neighbor_count_ff <= csr_write_data[FIELD_COUNT_W-1:0];
            CSR_QUERY_X:        query_x_ff        <= csr_write_data;
            CSR_QUERY_Y:        query_y_ff        <= csr_write_data;
            CSR_QUERY_Z:        query_z_ff        <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // effective k, saturated at the row length
   logic [KCMP_W-1:0] k_wide;
   logic [CNT_W-1:0]  k_eff;

   assign k_wide = (KCMP_W'(neighbor_count_ff) > KCMP_W'(K_MAX))
                   ? KCMP_W'(K_MAX) : KCMP_W'(neighbor_count_ff);
   assign k_eff  = k_wide[CNT_W-1:0];

   // coordinate as a COORD_WIDTH-bit two's complement value
   function automatic logic signed [COORD_WIDTH-1:0] coord(
      input logic [FIELD_COORD_W-1:0] v
   );
      logic [CX_W-1:0] wide;
      wide = CX_W'(v);
      return wide[COORD_WIDTH-1:0];
   endfunction

   // absolute difference of two coordinates
   function automatic logic [DIFF_W-1:0] abs_diff(
      input logic [FIELD_COORD_W-1:0] a,
      input logic [FIELD_COORD_W-1:0] b
   );
      logic signed [COORD_WIDTH-1:0] ca;
      logic signed [COORD_WIDTH-1:0] cb;
      logic signed [DIFF_W-1:0]      d;
      ca = coord(a);
      cb = coord(b);
      d  = DIFF_W'(ca) - DIFF_W'(cb);
      return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
   endfunction

   // point stage: differences to the query and end mark
   logic [DIFF_W-1:0] adiff_ff [3];
   logic              eoc_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         adiff_ff[0] <= abs_diff(req_payload.point_x, query_x_ff);
         adiff_ff[1] <= abs_diff(req_payload.point_y, query_y_ff);
         adiff_ff[2] <= abs_diff(req_payload.point_z, query_z_ff);
         eoc_ff      <= req_payload.end_of_cloud;
      end
   end

   // square stage
   logic [SQ_W-1:0] sq_ff [3];

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         for (int a = 0; a < 3; a++) begin
            sq_ff[a] <= adiff_ff[a] * adiff_ff[a];
         end
      end
   end

   // sum stage
   logic [DIST_W-1:0] dist_ff;

   always_ff @(posedge clock) begin
      if (cmd.sum) begin
         dist_ff <= DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) + DIST_W'(sq_ff[2]);
      end
   end

   // sorted row, kept count and arrival numbering
   logic [DIST_W-1:0]      dist_row_ff [K_MAX];
   logic [DIST_W-1:0]      dist_row_in [K_MAX];
   logic [INDEX_WIDTH-1:0] idx_row_ff  [K_MAX];
   logic [INDEX_WIDTH-1:0] idx_row_in  [K_MAX];
   logic [CNT_W-1:0]       kept_ff;
   logic [CNT_W-1:0]       kept_in;
   logic [ARR_W-1:0]       arrival_ff;
   logic [ARR_W-1:0]       arrival_in;
   logic [CNT_W-1:0]       n_cut;
   logic [CNT_W-1:0]       n_new;
   logic [K_MAX-1:0]       lt;
   logic [K_MAX-1:0]       lt_prev;
   logic                   full;
   logic                   index_ok;
   logic                   do_insert;

   // stored entries nearer than the new point form a prefix of the row
   always_comb begin
      n_cut = (kept_ff > k_eff) ? k_eff : kept_ff;
      full  = 1'b0;
      for (int j = 0; j < K_MAX; j++) begin
         lt[j] = (CNT_W'(j) < n_cut) && (dist_row_ff[j] < dist_ff);
         if ((CNT_W'(j + 1) == k_eff) && lt[j]) begin
            full = 1'b1;
         end
      end
      lt_prev   = K_MAX'({lt, 1'b1});
      index_ok  = !arrival_ff[INDEX_WIDTH];
      do_insert = index_ok && (k_eff != '0) && ((n_cut < k_eff) || !full);
      if (do_insert && (n_cut < k_eff)) begin
         n_new = n_cut + CNT_W'(1);
      end else begin
         n_new = n_cut;
      end
   end

   // row update: insert with shift right, or shift left while emitting
   always_comb begin
      dist_row_in = dist_row_ff;
      idx_row_in  = idx_row_ff;
      if (cmd.insert && do_insert) begin
         if (!lt[0]) begin
            dist_row_in[0] = dist_ff;
            idx_row_in[0]  = arrival_ff[INDEX_WIDTH-1:0];
         end
         for (int j = 1; j < K_MAX; j++) begin
            if (!lt[j]) begin
               if (lt_prev[j]) begin
                  dist_row_in[j] = dist_ff;
                  idx_row_in[j]  = arrival_ff[INDEX_WIDTH-1:0];
               end else begin
                  dist_row_in[j] = dist_row_ff[j-1];
                  idx_row_in[j]  = idx_row_ff[j-1];
               end
            end
         end
      end else if (cmd.emit) begin
         for (int j = 0; j < K_MAX - 1; j++) begin
            dist_row_in[j] = dist_row_ff[j+1];
            idx_row_in[j]  = idx_row_ff[j+1];
         end
      end
   end

   // count and numbering next values
   always_comb begin
      kept_in    = kept_ff;
      arrival_in = arrival_ff;
      if (cmd.insert) begin
         if (eoc_ff) begin
            kept_in    = '0;
            arrival_in = '0;
         end else begin
            kept_in = n_new;
            if (index_ok) begin
               arrival_in = arrival_ff + ARR_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      dist_row_ff <= dist_row_in;
      idx_row_ff  <= idx_row_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kept_ff    <= '0;
         arrival_ff <= '0;
      end else begin
         kept_ff    <= kept_in;
         arrival_ff <= arrival_in;
      end
   end

   // emission counters
   logic [CNT_W-1:0]      emit_left_ff;
   logic [OUT_RANK_W-1:0] rank_ff;

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         emit_left_ff <= n_new;
         rank_ff      <= '0;
      end else if (cmd.emit) begin
         if (emit_left_ff != '0) begin
            emit_left_ff <= emit_left_ff - CNT_W'(1);
         end
         rank_ff <= rank_ff + OUT_RANK_W'(1);
      end
   end

   // result register
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_ff;
   rsp_payload_type       rsp_in;
   logic [IDX_EXT_W-1:0]  idx_ext;
   logic [DIST_EXT_W-1:0] dist_ext;

   assign idx_ext  = IDX_EXT_W'(idx_row_ff[0]);
   assign dist_ext = DIST_EXT_W'(dist_row_ff[0]);

   always_comb begin
      if (emit_left_ff == '0) begin
         rsp_in.neighbor_index = '0;
         rsp_in.sqr_distance   = '0;
         rsp_in.rank           = '0;
         rsp_in.empty_result   = 1'b1;
         rsp_in.last_of_run    = 1'b1;
      end else begin
         rsp_in.neighbor_index = idx_ext[OUT_INDEX_W-1:0];
         rsp_in.sqr_distance   = dist_ext[OUT_DIST_W-1:0];
         rsp_in.rank           = rank_ff;
         rsp_in.empty_result   = 1'b0;
         rsp_in.last_of_run    = (emit_left_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // status to the controller
   assign status.end_of_cloud = eoc_ff;
   assign status.out_free     = !rsp_valid_ff || !rsp_stall;
   assign status.emit_done    = (emit_left_ff <= CNT_W'(1));

   // the row never holds more than its length
   assert property (@(posedge clock) disable iff (reset) kept_ff <= CNT_W'(K_MAX))
      else $error("knn_datapath: kept count beyond row length");

   // numbering stops at the end of the index range
   assert property (@(posedge clock) disable iff (reset)
      arrival_ff <= (ARR_W'(1) << INDEX_WIDTH))
      else $error("knn_datapath: arrival counter past its limit");

   // an empty result is the only and final one of its run
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.empty_result) |-> (rsp_ff.last_of_run && rsp_ff.rank == '0))
      else $error("knn_datapath: empty result not a lone final result");

endmodule
